[rtl/assert_macros.svh]
// Assertion helper macros for the SHA-1 stream hasher.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/sha1s_pkg.sv]
// Shared types and constants for the SHA-1 stream hasher.
// No dependencies.
package sha1s_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned NUM_DIGEST_WORDS = 5;

	localparam logic [WORD_W-1:0] IV [NUM_DIGEST_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [WORD_W-1:0] K_0 = 32'h5A827999;
	localparam logic [WORD_W-1:0] K_1 = 32'h6ED9EBA1;
	localparam logic [WORD_W-1:0] K_2 = 32'h8F1BBCDC;
	localparam logic [WORD_W-1:0] K_3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [2:0] WORD_LAST = 3'd4;

	typedef struct packed {
		logic [7:0] data;
		logic byte_valid;
		logic last;
	} item_t;

	typedef struct packed {
		logic compressing;
		logic emitting;
		logic [6:0] round;
	} core_stat_t;

endpackage

[rtl/sha1s_front.sv]
// Front end: accepts input beats, drops beats that carry neither a byte nor an end mark,
// and queues the rest for the core. Depends on sha1s_pkg.
module sha1s_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sha1s_pkg::item_t in_item,
	output logic q_valid,
	input  logic q_ready,
	output sha1s_pkg::item_t q_item
);

	sha1s_pkg::item_t fifo_q [4];
	logic [2:0] wr_ptr_q, rd_ptr_q;
	logic full, empty, push, pop;

	assign full = (wr_ptr_q[1:0] == rd_ptr_q[1:0]) && (wr_ptr_q[2] != rd_ptr_q[2]);
	assign empty = (wr_ptr_q == rd_ptr_q);
	assign in_ready = !full;
	assign push = in_valid && !full && (in_item.byte_valid || in_item.last);
	assign q_valid = !empty;
	assign q_item = fifo_q[rd_ptr_q[1:0]];
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 3'd1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q[1:0]] <= in_item;
		end
	end

endmodule

[rtl/sha1s_core.sv]
// Back end: byte packing, padding, 80-round compression and digest output.
// Depends on sha1s_pkg.
module sha1s_core (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  sha1s_pkg::item_t item,
	output logic dig_valid,
	input  logic dig_ready,
	output logic [31:0] dig_word,
	output logic [2:0] dig_index,
	output logic dig_last,
	output sha1s_pkg::core_stat_t stat
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_ADD = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	localparam logic [1:0] PAD_FIRST = 2'd0;
	localparam logic [1:0] PAD_ZERO = 2'd1;
	localparam logic [1:0] PAD_LEN = 2'd2;

	logic [2:0] state_q, ret_q;
	logic [1:0] pad_q;
	logic [5:0] pos_q;
	logic [63:0] bits_q;
	logic [6:0] round_q;
	logic [2:0] idx_q;
	logic [31:0] chain_q [5];
	logic [31:0] work_q [5];
	logic [31:0] sched_q [16];

	logic fire, place_en;
	logic [7:0] place_byte, len_byte;
	logic [63:0] len_shift;
	logic [5:0] pos_next;
	logic [31:0] f, k, t, w_new;
	logic [31:0] a, b, c, d, e;

	assign item_ready = (state_q == ST_IDLE);
	assign fire = item_valid && item_ready;
	assign pos_next = pos_q + 6'd1;
	assign len_shift = bits_q >> {~pos_q[2:0], 3'b000};
	assign len_byte = len_shift[7:0];

	always_comb begin
		place_en = 1'b0;
		place_byte = item.data;
		if (state_q == ST_IDLE) begin
			place_en = fire && item.byte_valid;
		end else if (state_q == ST_PAD) begin
			place_en = 1'b1;
			case (pad_q)
				PAD_FIRST: place_byte = sha1s_pkg::PAD_MARK;
				PAD_LEN: place_byte = len_byte;
				default: place_byte = 8'h00;
			endcase
		end
	end

	assign a = work_q[0];
	assign b = work_q[1];
	assign c = work_q[2];
	assign d = work_q[3];
	assign e = work_q[4];

	always_comb begin
		if (round_q < 7'd20) begin
			f = (b & c) | (~b & d);
			k = sha1s_pkg::K_0;
		end else if (round_q < 7'd40) begin
			f = b ^ c ^ d;
			k = sha1s_pkg::K_1;
		end else if (round_q < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
			k = sha1s_pkg::K_2;
		end else begin
			f = b ^ c ^ d;
			k = sha1s_pkg::K_3;
		end
	end

	assign t = {a[26:0], a[31:27]} + f + e + k + sched_q[0];
	assign w_new = {sched_q[13][30:0] ^ sched_q[8][30:0] ^ sched_q[2][30:0] ^ sched_q[0][30:0],
		sched_q[13][31] ^ sched_q[8][31] ^ sched_q[2][31] ^ sched_q[0][31]};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			pad_q <= PAD_FIRST;
			pos_q <= '0;
			bits_q <= '0;
			round_q <= '0;
			idx_q <= '0;
			for (int i = 0; i < 5; i++) begin
				chain_q[i] <= sha1s_pkg::IV[i];
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (fire) begin
						if (item.byte_valid) begin
							pos_q <= pos_next;
							bits_q <= bits_q + 64'd8;
						end
						pad_q <= PAD_FIRST;
						if (item.byte_valid && pos_q == sha1s_pkg::LAST_POS) begin
							state_q <= ST_ROUND;
							ret_q <= item.last ? ST_PAD : ST_IDLE;
						end else if (item.last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pos_q <= pos_next;
					if (pad_q != PAD_LEN) begin
						pad_q <= (pos_next == sha1s_pkg::LEN_POS) ? PAD_LEN : PAD_ZERO;
					end
					if (pos_q == sha1s_pkg::LAST_POS) begin
						state_q <= ST_ROUND;
						ret_q <= (pad_q == PAD_LEN) ? ST_EMIT : ST_PAD;
					end
				end
				ST_ROUND: begin
					if (round_q == sha1s_pkg::LAST_ROUND) begin
						round_q <= '0;
						state_q <= ST_ADD;
					end else begin
						round_q <= round_q + 7'd1;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < 5; i++) begin
						chain_q[i] <= chain_q[i] + work_q[i];
					end
					state_q <= ret_q;
				end
				ST_EMIT: begin
					if (dig_ready) begin
						if (idx_q == sha1s_pkg::WORD_LAST) begin
							idx_q <= '0;
							pos_q <= '0;
							bits_q <= '0;
							state_q <= ST_IDLE;
							for (int i = 0; i < 5; i++) begin
								chain_q[i] <= sha1s_pkg::IV[i];
							end
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: working words and rolling schedule
	always_ff @(posedge clk) begin
		if (state_q == ST_ROUND) begin
			work_q[0] <= t;
			work_q[1] <= a;
			work_q[2] <= {b[1:0], b[31:2]};
			work_q[3] <= c;
			work_q[4] <= d;
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i+1];
			end
			sched_q[15] <= w_new;
		end else begin
			if (place_en && pos_q == sha1s_pkg::LAST_POS) begin
				for (int i = 0; i < 5; i++) begin
					work_q[i] <= chain_q[i];
				end
			end
			for (int wi = 0; wi < 16; wi++) begin
				for (int l = 0; l < 4; l++) begin
					if (place_en && pos_q[5:2] == 4'(wi) && pos_q[1:0] == 2'(3 - l)) begin
						sched_q[wi][8*l +: 8] <= place_byte;
					end
				end
			end
		end
	end

	assign dig_valid = (state_q == ST_EMIT);
	assign dig_word = chain_q[idx_q];
	assign dig_index = idx_q;
	assign dig_last = (idx_q == sha1s_pkg::WORD_LAST);

	assign stat.compressing = (state_q == ST_ROUND);
	assign stat.emitting = (state_q == ST_EMIT);
	assign stat.round = round_q;

endmodule

[rtl/sha1_stream_hasher.sv]
// SHA-1 stream hasher: one byte per beat in, five 32-bit digest beats out per message.
// An accepted byte sits in the 4-beat input queue and is packed when the core is idle;
// a full block then goes through the 80 rounds and the add into the chaining words.
// The core takes no bytes while it compresses or emits, though the queue still accepts beats;
// finishing adds 9..72 padding bytes, one or two compressions and 5 digest beats.
// Reset (arst_n low, async): chaining words to the initial value, length and queue empty.
// Depends on sha1s_pkg, sha1s_front, sha1s_core and assert_macros.svh.
`include "assert_macros.svh"
module sha1_stream_hasher (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic s_axis_tuser,         // [0] byte_valid
	input  logic s_axis_tlast,         // last_byte
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] digest_word
	output logic [2:0] m_axis_tuser,   // [2:0] word_index
	output logic m_axis_tlast          // last_word
);

	sha1s_pkg::item_t in_item, q_item;
	sha1s_pkg::core_stat_t stat;
	logic q_valid, q_ready;

	assign in_item.data = s_axis_tdata;
	assign in_item.byte_valid = s_axis_tuser;
	assign in_item.last = s_axis_tlast;

	// Front: classify and queue incoming beats.
	sha1s_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_item(in_item),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_item(q_item)
	);

	// Back: pack, pad, compress, emit digest straight from the chaining registers.
	sha1s_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(q_valid),
		.item_ready(q_ready),
		.item(q_item),
		.dig_valid(m_axis_tvalid),
		.dig_ready(m_axis_tready),
		.dig_word(m_axis_tdata),
		.dig_index(m_axis_tuser),
		.dig_last(m_axis_tlast),
		.stat(stat)
	);

	// The round counter only moves while compressing.
	`ASSERT_NOW(a_round_idle, !stat.compressing, stat.round == 7'd0, "round count outside compression")
	// Core takes no queued item while compressing or emitting.
	`ASSERT_NOW(a_no_pop_busy, stat.compressing || stat.emitting, !q_ready, "queue popped while busy")
	// A non-final digest beat taken is followed by the next digest beat.
	`ASSERT_NEXT(a_digest_run, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
		m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1, "digest run broken")

endmodule

[bench/tb_sha1_stream_hasher.sv]
// Testbench for the SHA-1 stream hasher: byte beats in, five digest word beats out.
// Predicts digests with its own SHA-1 model in a scoreboard class; needs sha1s_pkg and the RTL.
module tb_sha1_stream_hasher;
	timeunit 1ns;
	timeprecision 1ps;

	// one expected digest beat
	typedef struct {
		logic [31:0] word;
		logic [2:0] idx;
		logic last;
	} digest_beat_t;

	// scoreboard: holds a SHA-1 predictor and the queue of expected digest beats
	class digest_scoreboard;
		logic [31:0] chain [5];
		logic [31:0] blk [16];
		logic [63:0] nbits;
		digest_beat_t pending [$];
		int errors;
		int messages;
		int beats_seen;

		// one line per mismatch, counted
		task report_mismatch(string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		function void clear();
			for (int i = 0; i < 5; i++)
				chain[i] = sha1s_pkg::IV[i];
			nbits = '0;
		endfunction

		function logic [31:0] rol(logic [31:0] v, int n);
			return (v << n) | (v >> (32 - n));
		endfunction

		function void compress();
			logic [31:0] a, b, c, d, e, f, k, t, w [80];
			for (int r = 0; r < 80; r++)
				w[r] = (r < 16) ? blk[r] :
					rol(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
			a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
			for (int r = 0; r < 80; r++) begin
				if (r < 20) begin
					f = (b & c) | (~b & d); k = sha1s_pkg::K_0;
				end else if (r < 40) begin
					f = b ^ c ^ d; k = sha1s_pkg::K_1;
				end else if (r < 60) begin
					f = (b & c) | (b & d) | (c & d); k = sha1s_pkg::K_2;
				end else begin
					f = b ^ c ^ d; k = sha1s_pkg::K_3;
				end
				t = rol(a, 5) + f + e + k + w[r];
				e = d; d = c; c = rol(b, 30); b = a; a = t;
			end
			chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
		endfunction

		function void put_byte(int pos, logic [7:0] v);
			int sh;
			sh = (3 - (pos % 4)) * 8;
			if (pos % 4 == 0)
				blk[pos / 4] = 32'(v) << sh;
			else
				blk[pos / 4] |= 32'(v) << sh;
			if (pos == 63)
				compress();
		endfunction

		// an accepted input beat
		function void note_input(logic [7:0] data, logic valid, logic last);
			logic [63:0] len;
			int pos;
			digest_beat_t db;
			if (valid) begin
				put_byte(int'(nbits[8:3]), data);
				nbits += 8;
			end
			if (!last)
				return;
			len = nbits;
			pos = int'(len[8:3]);
			put_byte(pos, sha1s_pkg::PAD_MARK);
			pos = (pos + 1) % 64;
			while (pos != 56) begin
				put_byte(pos, 8'h00);
				pos = (pos + 1) % 64;
			end
			for (int i = 0; i < 8; i++)
				put_byte(56 + i, len[(7 - i) * 8 +: 8]);
			for (int i = 0; i < 5; i++) begin
				db.word = chain[i];
				db.idx = 3'(i);
				db.last = (i == 4);
				pending.push_back(db);
			end
			messages++;
			clear();
		endfunction

		// an accepted output beat
		task check_output(logic [31:0] word, logic [2:0] idx, logic last);
			digest_beat_t db;
			beats_seen++;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected digest beat %h", word));
				return;
			end
			db = pending.pop_front();
			if (word !== db.word)
				report_mismatch($sformatf("word %0d: got %h want %h", db.idx, word, db.word));
			if (idx !== db.idx)
				report_mismatch($sformatf("index: got %0d want %0d", idx, db.idx));
			if (last !== db.last)
				report_mismatch($sformatf("tlast on word %0d: got %b", db.idx, last));
		endtask
	endclass

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic s_axis_tuser, s_axis_tlast;
	logic m_axis_tvalid, m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic m_axis_tlast;

	digest_scoreboard sb;
	bit no_idle;     // last part of the run: no gaps on either side
	bit hold_sink;   // long receiver hold-off for the pressure test
	longint cycles;

	localparam longint CYCLE_LIMIT = 2_000_000;

	sha1_stream_hasher uut (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// drive inputs to known values, hold reset, then release it
	initial begin
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = 0;
		s_axis_tlast = 0;
		m_axis_tready = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
	end

	// one input beat; random gap before it unless in the quiet part
	task automatic send_beat(logic [7:0] d, logic v, logic l);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= d;
		s_axis_tuser <= v;
		s_axis_tlast <= l;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_input(d, v, l);
	endtask

	// a message of n random bytes; ends with a valid last byte or a bare last
	task automatic send_message(int n);
		bit bare;
		bare = (n == 0) || ($urandom_range(0, 1) == 1);
		for (int i = 0; i < n; i++) begin
			// occasional noise beat that the block ignores
			if ($urandom_range(0, 15) == 0)
				send_beat(8'($urandom), 0, 0);
			send_beat(8'($urandom), 1, (!bare && i == n - 1));
		end
		if (bare)
			send_beat(8'($urandom), 0, 1);
	endtask

	// receiver: random stall bursts, a long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				m_axis_tready <= 0;
				@(posedge clk);
			end else if (!no_idle && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				m_axis_tready <= 1;
				@(posedge clk);
			end
		end
	end

	// sample output beats
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_output(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int sent;
		cycles = 0;
		no_idle = 0;
		hold_sink = 0;
		sb = new();
		sb.clear();
		@(posedge arst_n);
		@(posedge clk);

		// directed: empty message, extremes, valid+last together, padding edges
		send_beat(8'h00, 0, 1);            // empty message
		send_beat(8'h00, 0, 0);            // ignored beat
		send_beat(8'hFF, 1, 1);            // single 0xFF, byte and last together
		send_beat(8'h00, 1, 0);
		send_beat(8'h00, 0, 1);            // single 0x00, bare last
		send_beat(8'hAA, 1, 0);
		send_beat(8'h55, 1, 1);
		send_message(55);                  // padding fits in one block
		send_message(56);                  // padding needs a second block
		send_message(64);                  // exactly one full block

		// pressure: receiver holds off while several short messages queue up
		hold_sink = 1;
		fork
			begin
				for (int i = 0; i < 4; i++)
					send_message($urandom_range(0, 3));
			end
			begin
				repeat (600) @(posedge clk);
				hold_sink = 0;
			end
		join

		// random messages, mostly short, sometimes past one or two blocks
		sent = 0;
		while (sent < 200) begin
			int n;
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 140) : $urandom_range(0, 20);
			if (sent > 150)
				no_idle = 1;
			send_message(n);
			sent += n + 1;
		end
		s_axis_tvalid <= 0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);

		$display("Hashed %0d messages, %0d digest beats checked, incl. empty and padding edges.",
			sb.messages, sb.beats_seen);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
